// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== hdl/mpd_pkg.sv =====
// Package: types, codes and constant tables of the publish deframer
package mpd_pkg;

   localparam int DEF_PREFIX_LENGTH    = 21;
   localparam int DEF_MAX_LENGTH_BYTES = 4;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 28;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_TOPIC_LENGTH    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STATE_PAYLOAD_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_COVER_LENGTH    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_COVER_LENGTH    = 2'd3;

   localparam logic [7:0]  RST_MAX_TOPIC_LENGTH    = 8'd160;
   localparam logic [9:0]  RST_STATE_PAYLOAD_LIMIT = 10'd255;
   localparam logic [27:0] RST_MAX_COVER_LENGTH    = 28'd262144;
   localparam logic [15:0] RST_MIN_COVER_LENGTH    = 16'd128;

   localparam logic [7:0] JPEG_SOI_0 = 8'hff;
   localparam logic [7:0] JPEG_SOI_1 = 8'hd8;

   typedef enum logic [3:0] {
      KIND_HEADER    = 4'd0,
      KIND_LENGTH    = 4'd1,
      KIND_TOPIC_LEN = 4'd2,
      KIND_TOPIC     = 4'd3,
      KIND_PACKET_ID = 4'd4,
      KIND_STATE     = 4'd5,
      KIND_COVER     = 4'd6,
      KIND_DISCARD   = 4'd7,
      KIND_PING      = 4'd8,
      KIND_ERROR     = 4'd9
   } kind_type;

   localparam logic [3:0] PKT_TYPE_PUBLISH = 4'd3;

   typedef struct packed {
      logic [7:0]  max_topic_length;
      logic [9:0]  state_payload_limit;
      logic [27:0] max_cover_length;
      logic [15:0] min_cover_length;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_out;
      logic        in_field_name;
      logic        packet_end;
      logic        payload_end;
      logic [27:0] delivered_count;
      logic        cover_valid;
   } rsp_type;

   localparam logic [7:0] PREFIX_ROM [64] = '{
      8'h73, 8'h68, 8'h61, 8'h69, 8'h72, 8'h70, 8'h6f, 8'h72,
      8'h74, 8'h2f, 8'h6c, 8'h69, 8'h76, 8'h69, 8'h6e, 8'h67,
      8'h72, 8'h6f, 8'h6f, 8'h6d, 8'h2f, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam int COVER_NAME_LENGTH = 5;

   localparam logic [7:0] COVER_ROM [8] = '{
      8'h63, 8'h6f, 8'h76, 8'h65, 8'h72, 8'h00, 8'h00, 8'h00
   };

endpackage

// ===== hdl/mpd_csr.sv =====
// Configuration registers of the publish deframer
module mpd_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [mpd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mpd_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output mpd_pkg::cfg_type                      cfg
);
   import mpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_TOPIC_LENGTH:    cfg_in.max_topic_length    = csr_wdata[7:0];
            CSR_STATE_PAYLOAD_LIMIT: cfg_in.state_payload_limit = csr_wdata[9:0];
            CSR_MAX_COVER_LENGTH:    cfg_in.max_cover_length    = csr_wdata[27:0];
            CSR_MIN_COVER_LENGTH:    cfg_in.min_cover_length    = csr_wdata[15:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_topic_length    <= RST_MAX_TOPIC_LENGTH;
         cfg_ff.state_payload_limit <= RST_STATE_PAYLOAD_LIMIT;
         cfg_ff.max_cover_length    <= RST_MAX_COVER_LENGTH;
         cfg_ff.min_cover_length    <= RST_MIN_COVER_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/mpd_parser.sv =====
// Packet parser: per-byte state update and result register
module mpd_parser #(
   parameter int PREFIX_LENGTH    = mpd_pkg::DEF_PREFIX_LENGTH,
   parameter int MAX_LENGTH_BYTES = mpd_pkg::DEF_MAX_LENGTH_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              event_req,
   input  logic [7:0]        rx_byte,
   input  mpd_pkg::cfg_type  cfg,
   output mpd_pkg::rsp_type  rsp
);
   import mpd_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR,
      PH_LEN,
      PH_TLEN,
      PH_TOPIC,
      PH_PID,
      PH_STATE,
      PH_COVER,
      PH_DISCARD
   } phase_type;

   localparam logic [8:0] PrefixSize   = 9'(PREFIX_LENGTH);
   localparam logic [7:0] PrefixSize8  = 8'(PREFIX_LENGTH);
   localparam logic [15:0] CoverTopic = 16'(PREFIX_LENGTH + COVER_NAME_LENGTH);
   localparam logic [2:0] MaxLenBytes = 3'(MAX_LENGTH_BYTES);

   phase_type   phase_ff, phase_in;
   logic [7:0]  flags_ff, flags_in;
   logic [27:0] remaining_ff, remaining_in;
   logic [1:0]  len_index_ff, len_index_in;
   logic [15:0] topic_size_ff, topic_size_in;
   logic [7:0]  topic_index_ff, topic_index_in;
   logic        prefix_ok_ff, prefix_ok_in;
   logic        cover_name_ff, cover_name_in;
   logic [27:0] payload_count_ff, payload_count_in;
   logic [1:0]  jpeg_ok_ff, jpeg_ok_in;
   rsp_type     rsp_ff, rsp_in;

   logic [27:0] len_shifted;
   logic [27:0] len_value;
   logic [2:0]  len_index_inc;
   logic [27:0] remaining_dec;
   logic        at_end;
   logic [7:0]  topic_index_inc;
   logic [15:0] topic_size_shift;
   logic [7:0]  cover_pos;
   logic        topic_last;
   logic [27:0] payload_inc;
   logic        is_publish;

   function automatic phase_type payload_phase(
      input logic        pm,
      input logic        cm,
      input logic [27:0] rc,
      input logic [27:0] max_cover
   );
      phase_type ph;
      if (!pm) begin
         ph = PH_DISCARD;
      end else if (cm) begin
         ph = (rc == '0 || rc > max_cover) ? PH_DISCARD : PH_COVER;
      end else begin
         ph = PH_STATE;
      end
      return ph;
   endfunction

   always_comb begin
      case (len_index_ff)
         2'd0:    len_shifted = {21'd0, rx_byte[6:0]};
         2'd1:    len_shifted = {14'd0, rx_byte[6:0], 7'd0};
         2'd2:    len_shifted = {7'd0, rx_byte[6:0], 14'd0};
         default: len_shifted = {rx_byte[6:0], 21'd0};
      endcase
   end

   assign len_value        = remaining_ff | len_shifted;
   assign len_index_inc    = {1'b0, len_index_ff} + 3'd1;
   assign remaining_dec    = (remaining_ff != '0) ? remaining_ff - 28'd1 : '0;
   assign at_end           = (remaining_dec == '0);
   assign topic_index_inc  = topic_index_ff + 8'd1;
   assign topic_size_shift = {topic_size_ff[7:0], rx_byte};
   assign cover_pos        = topic_index_ff - PrefixSize8;
   assign topic_last       = ({8'd0, topic_index_ff} + 16'd1) >= topic_size_ff;
   assign payload_inc      = payload_count_ff + 28'd1;
   assign is_publish       = (flags_ff[7:4] == PKT_TYPE_PUBLISH);

   always_comb begin
      phase_in         = phase_ff;
      flags_in         = flags_ff;
      remaining_in     = remaining_ff;
      len_index_in     = len_index_ff;
      topic_size_in    = topic_size_ff;
      topic_index_in   = topic_index_ff;
      prefix_ok_in     = prefix_ok_ff;
      cover_name_in    = cover_name_ff;
      payload_count_in = payload_count_ff;
      jpeg_ok_in       = jpeg_ok_ff;
      rsp_in           = '0;
      rsp_in.kind      = KIND_DISCARD;
      rsp_in.byte_out  = rx_byte;

      if (event_req) begin
         rsp_in.byte_out = '0;
         rsp_in.kind     = (phase_ff == PH_HDR) ? KIND_PING : KIND_ERROR;
         phase_in        = PH_HDR;
      end else begin
         case (phase_ff)
            PH_HDR: begin
               rsp_in.kind  = KIND_HEADER;
               flags_in     = rx_byte;
               remaining_in = '0;
               len_index_in = '0;
               phase_in     = PH_LEN;
            end
            PH_LEN: begin
               remaining_in = len_value;
               rsp_in.kind  = KIND_LENGTH;
               if (rx_byte[7]) begin
                  if (len_index_inc >= MaxLenBytes) begin
                     rsp_in.kind = KIND_ERROR;
                     phase_in    = PH_HDR;
                  end else begin
                     len_index_in = len_index_inc[1:0];
                  end
               end else if (is_publish && len_value >= 28'd2) begin
                  phase_in       = PH_TLEN;
                  topic_index_in = '0;
                  topic_size_in  = '0;
               end else begin
                  if (is_publish) begin
                     rsp_in.kind = KIND_ERROR;
                  end
                  if (len_value == '0) begin
                     rsp_in.packet_end = 1'b1;
                     phase_in          = PH_HDR;
                  end else begin
                     phase_in = PH_DISCARD;
                  end
               end
            end
            default: begin
               remaining_in = remaining_dec;
               case (phase_ff)
                  PH_TLEN: begin
                     rsp_in.kind    = KIND_TOPIC_LEN;
                     topic_size_in  = topic_size_shift;
                     topic_index_in = topic_index_inc;
                     if (topic_index_inc >= 8'd2) begin
                        if (topic_size_shift == '0 ||
                            topic_size_shift > {8'd0, cfg.max_topic_length} ||
                            remaining_dec < {12'd0, topic_size_shift}) begin
                           phase_in = PH_DISCARD;
                        end else begin
                           phase_in       = PH_TOPIC;
                           topic_index_in = '0;
                           prefix_ok_in   = 1'b1;
                           cover_name_in  = 1'b1;
                        end
                     end
                  end
                  PH_TOPIC: begin
                     rsp_in.kind = KIND_TOPIC;
                     if ({1'b0, topic_index_ff} < PrefixSize) begin
                        if (rx_byte != PREFIX_ROM[topic_index_ff[5:0]]) begin
                           prefix_ok_in = 1'b0;
                        end
                     end else begin
                        rsp_in.in_field_name = prefix_ok_ff;
                        if (cover_pos >= 8'(COVER_NAME_LENGTH) ||
                            rx_byte != COVER_ROM[cover_pos[2:0]]) begin
                           cover_name_in = 1'b0;
                        end
                     end
                     topic_index_in = topic_index_inc;
                     if (topic_last) begin
                        if (topic_size_ff != CoverTopic) begin
                           cover_name_in = 1'b0;
                        end
                        if (flags_ff[2:1] != 2'd0) begin
                           if (remaining_dec < 28'd2) begin
                              rsp_in.kind = KIND_ERROR;
                              phase_in    = PH_DISCARD;
                           end else begin
                              phase_in       = PH_PID;
                              topic_index_in = '0;
                           end
                        end else begin
                           payload_count_in = '0;
                           jpeg_ok_in       = '0;
                           phase_in = payload_phase(prefix_ok_in, cover_name_in,
                                                    remaining_dec, cfg.max_cover_length);
                        end
                     end
                  end
                  PH_PID: begin
                     rsp_in.kind    = KIND_PACKET_ID;
                     topic_index_in = topic_index_inc;
                     if (topic_index_inc >= 8'd2) begin
                        payload_count_in = '0;
                        jpeg_ok_in       = '0;
                        phase_in = payload_phase(prefix_ok_ff, cover_name_ff,
                                                 remaining_dec, cfg.max_cover_length);
                     end
                  end
                  PH_STATE: begin
                     if (payload_count_ff < {18'd0, cfg.state_payload_limit}) begin
                        payload_count_in       = payload_inc;
                        rsp_in.kind            = KIND_STATE;
                        rsp_in.delivered_count = payload_inc;
                        rsp_in.payload_end     =
                           (payload_inc == {18'd0, cfg.state_payload_limit}) || at_end;
                     end
                  end
                  PH_COVER: begin
                     payload_count_in = payload_inc;
                     if (payload_inc == 28'd1 && rx_byte == JPEG_SOI_0) begin
                        jpeg_ok_in[0] = 1'b1;
                     end
                     if (payload_inc == 28'd2 && rx_byte == JPEG_SOI_1) begin
                        jpeg_ok_in[1] = 1'b1;
                     end
                     rsp_in.kind            = KIND_COVER;
                     rsp_in.delivered_count = payload_inc;
                     if (at_end) begin
                        rsp_in.payload_end = 1'b1;
                        rsp_in.cover_valid =
                           (payload_inc >= {12'd0, cfg.min_cover_length}) &&
                           (jpeg_ok_in == 2'b11);
                     end
                  end
                  default: begin
                     rsp_in.kind = KIND_DISCARD;
                  end
               endcase
               if (at_end) begin
                  rsp_in.packet_end = 1'b1;
                  phase_in          = PH_HDR;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HDR;
         flags_ff         <= '0;
         remaining_ff     <= '0;
         len_index_ff     <= '0;
         topic_size_ff    <= '0;
         topic_index_ff   <= '0;
         prefix_ok_ff     <= 1'b1;
         cover_name_ff    <= 1'b1;
         payload_count_ff <= '0;
         jpeg_ok_ff       <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         flags_ff         <= flags_in;
         remaining_ff     <= remaining_in;
         len_index_ff     <= len_index_in;
         topic_size_ff    <= topic_size_in;
         topic_index_ff   <= topic_index_in;
         prefix_ok_ff     <= prefix_ok_in;
         cover_name_ff    <= cover_name_in;
         payload_count_ff <= payload_count_in;
         jpeg_ok_ff       <= jpeg_ok_in;
         rsp_ff           <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== hdl/mqtt_publish_deframer_core.sv =====
// Top level of the publish deframer: handshake, configuration and parser
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | event_req, rx_byte
//   rsp_    | out       | rsp_valid/rsp_stall | kind, byte_out, flags, counts
//   csr_    | in        | csr_write_enable    | csr_index, csr_wdata
//
// One word in, one word out; one word per cycle while req_stall is low.
// Output is registered: parser state and result register load together.
// req_stall rises only while a result is held and rsp_stall is high.
// Synchronous reset returns the parser to expecting a fixed header.
module mqtt_publish_deframer_core #(
   parameter int PREFIX_LENGTH    = mpd_pkg::DEF_PREFIX_LENGTH,
   parameter int MAX_LENGTH_BYTES = mpd_pkg::DEF_MAX_LENGTH_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_event_req,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [3:0]                          rsp_kind,
   output logic [7:0]                          rsp_byte_out,
   output logic                                rsp_in_field_name,
   output logic                                rsp_packet_end,
   output logic                                rsp_payload_end,
   output logic [27:0]                         rsp_delivered_count,
   output logic                                rsp_cover_valid,
   input  logic                                csr_write_enable,
   input  logic [mpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mpd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import mpd_pkg::*;

   cfg_type cfg;
   rsp_type rsp;
   logic    accept;
   logic    rsp_valid_ff, rsp_valid_in;

   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   mpd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   mpd_parser #(
      .PREFIX_LENGTH    (PREFIX_LENGTH),
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .event_req (req_event_req),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg),
      .rsp       (rsp)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp.kind;
   assign rsp_byte_out        = rsp.byte_out;
   assign rsp_in_field_name   = rsp.in_field_name;
   assign rsp_packet_end      = rsp.packet_end;
   assign rsp_payload_end     = rsp.payload_end;
   assign rsp_delivered_count = rsp.delivered_count;
   assign rsp_cover_valid     = rsp.cover_valid;

endmodule

// ===== hdl/mpd_checker.sv =====
// Port checker for the publish deframer, bound to the top level
`include "assert_macros.svh"

module mpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_kind,
   input logic [7:0]  rsp_byte_out,
   input logic        rsp_in_field_name,
   input logic        rsp_packet_end,
   input logic        rsp_payload_end,
   input logic [27:0] rsp_delivered_count,
   input logic        rsp_cover_valid
);
   import mpd_pkg::*;

   `ASSERT_NEXT(a_stalled_word_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_byte_out) && $stable(rsp_delivered_count))

   `ASSERT_NEXT(a_accept_gives_word, clock, reset, req_valid && !req_stall, rsp_valid)

   `ASSERT_IMPLY(a_count_only_on_payload, clock, reset,
      rsp_valid && rsp_kind != KIND_STATE && rsp_kind != KIND_COVER,
      rsp_delivered_count == 28'd0 && !rsp_payload_end)

   `ASSERT_IMPLY(a_cover_valid_at_end, clock, reset, rsp_valid && rsp_cover_valid,
      rsp_kind == KIND_COVER && rsp_payload_end && rsp_packet_end)

   `ASSERT_IMPLY(a_field_name_in_topic, clock, reset, rsp_valid && rsp_in_field_name,
      rsp_kind == KIND_TOPIC || rsp_kind == KIND_ERROR)

endmodule

bind mqtt_publish_deframer_core mpd_checker u_checker (.*);

// ===== dv/tb_mqtt_publish_deframer_core.sv =====
// Testbench of the publish deframer core: packet stimulus, byte-level prediction and checking
module tb_mqtt_publish_deframer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mpd_pkg::*;

   localparam int PREFIX_SIZE   = DEF_PREFIX_LENGTH;
   localparam int LEN_BYTES_MAX = DEF_MAX_LENGTH_BYTES;
   localparam int FIELD_LEN     = 5;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 250;
   localparam logic [7:0] JPEG_MARK0 = 8'hff;
   localparam logic [7:0] JPEG_MARK1 = 8'hd8;

   localparam logic [7:0] TOPIC_PREFIX [PREFIX_SIZE] = '{
      8'h73, 8'h68, 8'h61, 8'h69, 8'h72, 8'h70, 8'h6f, 8'h72, 8'h74, 8'h2f,
      8'h6c, 8'h69, 8'h76, 8'h69, 8'h6e, 8'h67, 8'h72, 8'h6f, 8'h6f, 8'h6d, 8'h2f
   };
   localparam logic [7:0] FIELD_COVER [FIELD_LEN] = '{8'h63, 8'h6f, 8'h76, 8'h65, 8'h72};

   typedef enum logic [2:0] {
      ST_HEADER, ST_LENGTH, ST_TOPIC_LEN, ST_TOPIC, ST_PACKET_ID, ST_STATE, ST_COVER, ST_DISCARD
   } parse_state_type;

   typedef enum int {
      SHAPE_COVER, SHAPE_FIELD, SHAPE_BAD_PREFIX, SHAPE_FOREIGN, SHAPE_PREFIX_ONLY,
      SHAPE_LONG, SHAPE_BAD_TLEN
   } topic_shape_type;

   typedef struct packed {
      logic       ev;
      logic [7:0] data;
   } rx_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_event_req = 1'b0;
   logic [7:0]                 req_rx_byte = 8'd0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [3:0]                 rsp_kind;
   logic [7:0]                 rsp_byte_out;
   logic                       rsp_in_field_name;
   logic                       rsp_packet_end;
   logic                       rsp_payload_end;
   logic [27:0]                rsp_delivered_count;
   logic                       rsp_cover_valid;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   rx_word_type pending_words[$];
   rsp_type     expected_rsps[$];

   bit   word_taken = 1'b0;
   bit   steady = 1'b0;
   logic hold_on = 1'b0;
   event hold_go;

   int errors = 0;
   int cycles = 0;
   int words_queued = 0;
   int words_in = 0;
   int rsps_checked = 0;
   int settings_applied = 0;
   int cover_valid_seen = 0;
   int kind_tally [16];

   // configuration mirror
   logic [7:0]  max_topic;
   logic [9:0]  state_limit;
   logic [27:0] max_cover;
   logic [15:0] min_cover;

   // parser mirror
   parse_state_type st;
   logic [7:0]      flags;
   logic [27:0]     remaining;
   logic [2:0]      len_index;
   logic [15:0]     topic_size;
   logic [7:0]      topic_pos;
   logic            prefix_ok;
   logic            cover_ok;
   logic [27:0]     payload_cnt;
   logic [1:0]      soi_seen;

   mqtt_publish_deframer_core DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_event_req       (req_event_req),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_byte_out        (rsp_byte_out),
      .rsp_in_field_name   (rsp_in_field_name),
      .rsp_packet_end      (rsp_packet_end),
      .rsp_payload_end     (rsp_payload_end),
      .rsp_delivered_count (rsp_delivered_count),
      .rsp_cover_valid     (rsp_cover_valid),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void init_deframer_mirror();
      max_topic   = 8'd160;
      state_limit = 10'd255;
      max_cover   = 28'd262144;
      min_cover   = 16'd128;
      st          = ST_HEADER;
      flags       = '0;
      remaining   = '0;
      len_index   = '0;
      topic_size  = '0;
      topic_pos   = '0;
      prefix_ok   = 1'b1;
      cover_ok    = 1'b1;
      payload_cnt = '0;
      soi_seen    = '0;
   endfunction

   function automatic void open_payload();
      payload_cnt = '0;
      soi_seen    = '0;
      if (!prefix_ok) begin
         st = ST_DISCARD;
      end else if (cover_ok) begin
         if (remaining == 0 || remaining > max_cover) st = ST_DISCARD;
         else st = ST_COVER;
      end else begin
         st = ST_STATE;
      end
   endfunction

   function automatic rsp_type deframe_step(input logic ev, input logic [7:0] b);
      rsp_type     r;
      logic        last;
      logic [31:0] acc;
      int unsigned idx;
      int unsigned pos;
      r = '0;
      r.kind = KIND_DISCARD;
      r.byte_out = b;
      if (ev) begin
         r.byte_out = 8'd0;
         if (st == ST_HEADER) r.kind = KIND_PING;
         else r.kind = KIND_ERROR;
         st = ST_HEADER;
      end else if (st == ST_LENGTH) begin
         idx = len_index & 3;
         acc = {4'd0, remaining} | (32'(b[6:0]) << (7 * idx));
         remaining = acc[27:0];
         r.kind = KIND_LENGTH;
         if (b[7]) begin
            if (idx + 1 >= LEN_BYTES_MAX) begin
               r.kind = KIND_ERROR;
               st = ST_HEADER;
            end else begin
               len_index = 3'(idx + 1);
            end
         end else if (flags[7:4] == PKT_TYPE_PUBLISH && remaining >= 2) begin
            st = ST_TOPIC_LEN;
            topic_pos = '0;
            topic_size = '0;
         end else begin
            if (flags[7:4] == PKT_TYPE_PUBLISH) r.kind = KIND_ERROR;
            if (remaining == 0) begin
               r.packet_end = 1'b1;
               st = ST_HEADER;
            end else begin
               st = ST_DISCARD;
            end
         end
      end else if (st == ST_HEADER) begin
         r.kind = KIND_HEADER;
         flags = b;
         remaining = '0;
         len_index = '0;
         st = ST_LENGTH;
      end else begin
         if (remaining != 0) remaining = remaining - 1;
         last = (remaining == 0);
         case (st)
            ST_TOPIC_LEN: begin
               r.kind = KIND_TOPIC_LEN;
               topic_size = {topic_size[7:0], b};
               topic_pos = topic_pos + 1;
               if (topic_pos >= 2) begin
                  if (topic_size == 0 || topic_size > max_topic || remaining < topic_size) begin
                     st = ST_DISCARD;
                  end else begin
                     st = ST_TOPIC;
                     topic_pos = '0;
                     prefix_ok = 1'b1;
                     cover_ok = 1'b1;
                  end
               end
            end
            ST_TOPIC: begin
               pos = topic_pos;
               r.kind = KIND_TOPIC;
               if (pos < PREFIX_SIZE) begin
                  if (b != TOPIC_PREFIX[pos]) prefix_ok = 1'b0;
               end else begin
                  r.in_field_name = prefix_ok;
                  if (pos - PREFIX_SIZE >= FIELD_LEN) cover_ok = 1'b0;
                  else if (b != FIELD_COVER[pos - PREFIX_SIZE]) cover_ok = 1'b0;
               end
               topic_pos = 8'(pos + 1);
               if (pos + 1 >= topic_size) begin
                  if (topic_size != PREFIX_SIZE + FIELD_LEN) cover_ok = 1'b0;
                  if (flags[2:1] != 0) begin
                     if (remaining < 2) begin
                        r.kind = KIND_ERROR;
                        st = ST_DISCARD;
                     end else begin
                        st = ST_PACKET_ID;
                        topic_pos = '0;
                     end
                  end else begin
                     open_payload();
                  end
               end
            end
            ST_PACKET_ID: begin
               r.kind = KIND_PACKET_ID;
               topic_pos = topic_pos + 1;
               if (topic_pos >= 2) open_payload();
            end
            ST_STATE: begin
               if (payload_cnt < state_limit) begin
                  payload_cnt = payload_cnt + 1;
                  r.kind = KIND_STATE;
                  r.delivered_count = payload_cnt;
                  r.payload_end = (payload_cnt == state_limit) || last;
               end else begin
                  r.kind = KIND_DISCARD;
               end
            end
            ST_COVER: begin
               payload_cnt = payload_cnt + 1;
               if (payload_cnt == 1 && b == JPEG_MARK0) soi_seen[0] = 1'b1;
               if (payload_cnt == 2 && b == JPEG_MARK1) soi_seen[1] = 1'b1;
               r.kind = KIND_COVER;
               r.delivered_count = payload_cnt;
               if (last) begin
                  r.payload_end = 1'b1;
                  r.cover_valid = (payload_cnt >= min_cover) && (soi_seen == 2'b11);
               end
            end
            default: r.kind = KIND_DISCARD;
         endcase
         if (last) begin
            r.packet_end = 1'b1;
            st = ST_HEADER;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [27:0] got,
                                  input logic [27:0] want);
      $display("mismatch %s: got %0h want %0h at result %0d", what, got, want, rsps_checked);
      errors++;
   endtask

   task automatic put_byte(input logic [7:0] b);
      pending_words.push_back('{ev: 1'b0, data: b});
      words_queued++;
   endtask

   task automatic put_timeout();
      pending_words.push_back('{ev: 1'b1, data: 8'($urandom)});
      words_queued++;
   endtask

   task automatic put_length(input int unsigned n);
      int nb;
      logic [7:0] b;
      if (n < 128) nb = 1;
      else if (n < 16384) nb = 2;
      else if (n < 2097152) nb = 3;
      else nb = 4;
      if ($urandom_range(0, 2) == 0) nb = $urandom_range(nb, LEN_BYTES_MAX);
      for (int k = 0; k < nb; k++) begin
         b = 8'((n >> (7 * k)) & 127);
         if (k != nb - 1) b[7] = 1'b1;
         put_byte(b);
      end
   endtask

   function automatic topic_shape_type pick_shape();
      int s;
      s = $urandom_range(0, 99);
      if (s < 30) return SHAPE_COVER;
      if (s < 60) return SHAPE_FIELD;
      if (s < 70) return SHAPE_BAD_PREFIX;
      if (s < 80) return SHAPE_FOREIGN;
      if (s < 88) return SHAPE_PREFIX_ONLY;
      if (s < 90) return SHAPE_LONG;
      return SHAPE_BAD_TLEN;
   endfunction

   task automatic queue_publish(input topic_shape_type shape, input bit cut);
      logic [7:0]  topic[$];
      logic [7:0]  body[$];
      logic [1:0]  qos;
      logic [7:0]  hdr;
      bit          is_cover;
      int          name_len;
      int          plen;
      int          pid_len;
      int          keep;
      int          total;
      int unsigned tl_field;
      int unsigned rem_field;
      qos = 2'($urandom_range(0, 3));
      is_cover = (shape == SHAPE_COVER || shape == SHAPE_BAD_PREFIX || shape == SHAPE_BAD_TLEN);
      if (shape != SHAPE_FOREIGN && shape != SHAPE_PREFIX_ONLY)
         for (int j = 0; j < PREFIX_SIZE; j++) topic.push_back(TOPIC_PREFIX[j]);
      case (shape)
         SHAPE_COVER, SHAPE_BAD_TLEN: begin
            for (int j = 0; j < FIELD_LEN; j++) topic.push_back(FIELD_COVER[j]);
         end
         SHAPE_BAD_PREFIX: begin
            name_len = $urandom_range(0, PREFIX_SIZE - 1);
            topic[name_len] = topic[name_len] ^ 8'($urandom_range(1, 255));
            for (int j = 0; j < FIELD_LEN; j++) topic.push_back(FIELD_COVER[j]);
         end
         SHAPE_FIELD: begin
            name_len = $urandom_range(1, 9);
            for (int j = 0; j < name_len; j++)
               topic.push_back((j < FIELD_LEN && $urandom_range(0, 2) != 0) ?
                               FIELD_COVER[j] : 8'($urandom_range(8'h61, 8'h7a)));
         end
         SHAPE_FOREIGN: begin
            name_len = $urandom_range(1, 30);
            for (int j = 0; j < name_len; j++) topic.push_back(8'($urandom));
         end
         SHAPE_PREFIX_ONLY: begin
            name_len = $urandom_range(1, PREFIX_SIZE);
            for (int j = 0; j < name_len; j++) topic.push_back(TOPIC_PREFIX[j]);
         end
         default: begin
            total = $urandom_range(0, 1) ? $urandom_range(22, 60) : $urandom_range(61, 255);
            while (topic.size() < total) topic.push_back(8'($urandom));
         end
      endcase
      tl_field = topic.size();
      if (shape == SHAPE_BAD_TLEN)
         tl_field = $urandom_range(0, 1) ? 0 : tl_field + $urandom_range(1, 400);
      pid_len = (qos != 0) ? 2 : 0;
      if (is_cover) plen = $urandom_range(0, 24);
      else if ($urandom_range(0, 7) == 0) plen = $urandom_range(11, 40);
      else plen = $urandom_range(0, 10);
      if (qos != 0 && $urandom_range(0, 5) == 0) begin
         pid_len = $urandom_range(0, 1);
         plen = 0;
      end
      body.push_back(tl_field[15:8]);
      body.push_back(tl_field[7:0]);
      foreach (topic[j]) body.push_back(topic[j]);
      for (int j = 0; j < pid_len; j++) body.push_back(8'($urandom));
      for (int j = 0; j < plen; j++) begin
         if (is_cover && j == 0 && $urandom_range(0, 3) != 0) body.push_back(JPEG_MARK0);
         else if (is_cover && j == 1 && $urandom_range(0, 3) != 0) body.push_back(JPEG_MARK1);
         else body.push_back(8'($urandom));
      end
      rem_field = body.size();
      keep = body.size();
      if (cut) begin
         keep = $urandom_range(0, body.size());
         if ($urandom_range(0, 1)) rem_field = rem_field + $urandom_range(1, 4000);
         else rem_field = rem_field + $urandom_range(1, 28'hfffffff - body.size());
      end
      hdr = {PKT_TYPE_PUBLISH, 1'($urandom), qos, 1'($urandom)};
      put_byte(hdr);
      put_length(rem_field);
      for (int j = 0; j < keep; j++) put_byte(body[j]);
      if (cut) put_timeout();
   endtask

   task automatic queue_noise(input int r);
      logic [3:0] ptype;
      int n;
      if (r < 12) begin
         ptype = 4'($urandom_range(0, 15));
         if (ptype == PKT_TYPE_PUBLISH) ptype = 4'hc;
         put_byte({ptype, 4'($urandom)});
         n = $urandom_range(0, 6);
         put_length(n);
         for (int j = 0; j < n; j++) put_byte(8'($urandom));
      end else if (r < 19) begin
         put_byte({PKT_TYPE_PUBLISH, 4'($urandom)});
         n = $urandom_range(0, 1);
         put_length(n);
         for (int j = 0; j < n; j++) put_byte(8'($urandom));
      end else if (r < 25) begin
         put_byte(8'($urandom));
         for (int j = 0; j < LEN_BYTES_MAX; j++) put_byte(8'h80 | 8'($urandom_range(0, 127)));
      end else if (r < 30) begin
         put_timeout();
      end else begin
         n = $urandom_range(1, 3);
         for (int j = 0; j < n; j++) put_byte(8'($urandom));
      end
   endtask

   task automatic queue_random_traffic(input int target);
      int first;
      int r;
      first = words_queued;
      while (words_queued - first < target) begin
         r = $urandom_range(0, 99);
         if (r < 55) queue_publish(pick_shape(), 1'b0);
         else if (r < 65) queue_publish(pick_shape(), 1'b1);
         else queue_noise(r - 65);
      end
   endtask

   task automatic queue_directed();
      put_timeout();
      put_byte(8'h30); put_byte(8'h00);
      put_byte(8'h32); put_byte(8'h01); put_byte(8'h00);
      put_byte(8'hc0); put_byte(8'h00);
      put_byte(8'h3f); put_byte(8'hff); put_byte(8'hff); put_byte(8'hff); put_byte(8'hff);
      put_byte(8'h30); put_byte(8'h05); put_byte(8'h00); put_timeout();
      put_byte(8'h30); put_byte(8'h04); put_byte(8'h00); put_byte(8'h00);
      put_byte(8'haa); put_byte(8'hbb);
      put_byte(8'h00); put_byte(8'h00);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_MAX_TOPIC_LENGTH:    max_topic = value[7:0];
         CSR_STATE_PAYLOAD_LIMIT: state_limit = value[9:0];
         CSR_MAX_COVER_LENGTH:    max_cover = value[27:0];
         default:                 min_cover = value[15:0];
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] topic_max, input logic [9:0] limit,
                                 input logic [27:0] cover_max, input logic [15:0] cover_min);
      write_csr(CSR_MAX_TOPIC_LENGTH, 28'(topic_max));
      write_csr(CSR_STATE_PAYLOAD_LIMIT, 28'(limit));
      write_csr(CSR_MAX_COVER_LENGTH, cover_max);
      write_csr(CSR_MIN_COVER_LENGTH, 28'(cover_min));
      settings_applied++;
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || expected_rsps.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   always @(negedge clock) begin : drive_proc
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         word_taken = 1'b0;
         if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
            req_valid <= 1'b1;
            req_event_req <= pending_words[0].ev;
            req_rx_byte <= pending_words[0].data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : accept_proc
      if (!reset && req_valid && !req_stall) begin
         expected_rsps.push_back(deframe_step(req_event_req, req_rx_byte));
         pending_words.pop_front();
         words_in++;
         word_taken = 1'b1;
      end
   end

   always @(negedge clock) begin : sink_proc
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_on || (!steady && $urandom_range(0, 99) < 14);
   end

   initial begin : hold_proc
      forever begin
         @(hold_go);
         @(posedge clock);
         hold_on <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("result with nothing expected, kind", 28'(rsp_kind), 28'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch("kind", 28'(rsp_kind), 28'(want.kind));
            if (rsp_byte_out !== want.byte_out)
               report_mismatch("byte_out", 28'(rsp_byte_out), 28'(want.byte_out));
            if (rsp_in_field_name !== want.in_field_name)
               report_mismatch("in_field_name", 28'(rsp_in_field_name), 28'(want.in_field_name));
            if (rsp_packet_end !== want.packet_end)
               report_mismatch("packet_end", 28'(rsp_packet_end), 28'(want.packet_end));
            if (rsp_payload_end !== want.payload_end)
               report_mismatch("payload_end", 28'(rsp_payload_end), 28'(want.payload_end));
            if (rsp_delivered_count !== want.delivered_count)
               report_mismatch("delivered_count", rsp_delivered_count, want.delivered_count);
            if (rsp_cover_valid !== want.cover_valid)
               report_mismatch("cover_valid", 28'(rsp_cover_valid), 28'(want.cover_valid));
            kind_tally[want.kind]++;
            if (want.cover_valid) cover_valid_seen++;
         end
         rsps_checked++;
      end
   end

   always @(posedge clock) begin : watchdog_proc
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still queued", cycles, pending_words.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus_proc
      foreach (kind_tally[k]) kind_tally[k] = 0;
      init_deframer_mirror();
      repeat (9) @(negedge clock);
      reset = 1'b0;

      @(posedge clock);
      queue_directed();
      queue_random_traffic(180);
      drain();

      apply_settings(8'd255, 10'd1023, 28'hfffffff, 16'd0);
      @(posedge clock);
      steady = 1'b1;
      queue_random_traffic(200);
      drain();

      apply_settings(8'd26, 10'd1, 28'd1, 16'hffff);
      @(posedge clock);
      steady = 1'b0;
      queue_random_traffic(180);
      drain();

      apply_settings(8'd1, 10'd0, 28'd24, 16'd2);
      @(posedge clock);
      queue_random_traffic(60);
      drain();

      apply_settings(8'($urandom_range(26, 255)), 10'($urandom_range(1, 12)),
                     28'($urandom_range(4, 30)), 16'($urandom_range(0, 20)));
      @(posedge clock);
      queue_random_traffic(300);
      -> hold_go;
      drain();

      $display("%0d words driven, %0d results checked, %0d register settings applied",
               words_in, rsps_checked, settings_applied);
      $display("state bytes %0d, cover bytes %0d, valid covers %0d, pings %0d, errors %0d",
               kind_tally[KIND_STATE], kind_tally[KIND_COVER], cover_valid_seen,
               kind_tally[KIND_PING], kind_tally[KIND_ERROR]);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mpd_pkg.sv
hdl/mpd_csr.sv
hdl/mpd_parser.sv
hdl/mqtt_publish_deframer_core.sv
hdl/mpd_checker.sv
dv/tb_mqtt_publish_deframer_core.sv
